// File: hw/rtl/mqttpp_pkg.sv
// shared constants, codes and helpers for the mqtt publish packet parser
`timescale 1ns / 1ps

package mqttpp_pkg;

  // longest variable-byte integer accepted, in bytes
  localparam int unsigned MaxLengthBytes = 4;
  // septets that fit in the 28-bit accumulator
  localparam int unsigned SeptetLimit    = 4;

  localparam int unsigned LenW      = 28;
  localparam int unsigned CountW    = 3;
  localparam int unsigned RoleW     = 4;
  localparam int unsigned ErrW      = 2;
  localparam int unsigned OutFieldW = 8 + 4 + 2 + 1 + 16 + 16 + LenW + ErrW;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

  localparam logic [3:0] TypePublish = 4'd3;

  // byte roles
  localparam logic [RoleW-1:0] RoleHeader   = 4'd0;
  localparam logic [RoleW-1:0] RoleLength   = 4'd1;
  localparam logic [RoleW-1:0] RoleTopicLen = 4'd2;
  localparam logic [RoleW-1:0] RoleTopic    = 4'd3;
  localparam logic [RoleW-1:0] RolePacketId = 4'd4;
  localparam logic [RoleW-1:0] RoleProperty = 4'd5;
  localparam logic [RoleW-1:0] RolePayload  = 4'd6;
  localparam logic [RoleW-1:0] RoleOther    = 4'd7;
  localparam logic [RoleW-1:0] RoleDiscard  = 4'd8;

  // error codes
  localparam logic [ErrW-1:0] ErrNone      = 2'd0;
  localparam logic [ErrW-1:0] ErrBadType   = 2'd1;
  localparam logic [ErrW-1:0] ErrLenLong   = 2'd2;
  localparam logic [ErrW-1:0] ErrTruncated = 2'd3;

  typedef logic [LenW-1:0]   len_t;
  typedef logic [CountW-1:0] count_t;

  // add one septet of a variable-byte integer at its place
  function automatic len_t add_septet(input len_t acc, input logic [7:0] b,
                                      input count_t count);
    len_t sh;
    sh = len_t'(b[6:0]) << (5'(count[1:0]) * 5'd7);
    if (count < count_t'(SeptetLimit)) begin
      return acc + sh;
    end
    return acc;
  endfunction

endpackage

// File: hw/rtl/mqtt_publish_packet_parser_core.sv
// top level of the mqtt v5 publish packet parser
`timescale 1ns / 1ps

// mqtt v5 publish packet parser
//
// takes a raw byte stream on the slave channel, one byte per item, and gives
// one tagged item per byte on the master channel: the byte itself, its role
// (tuser), the header fields, topic length, packet id, remaining length and
// an error code, with tlast on the byte that ends a packet
// the result is registered: it becomes valid in the cycle after the input byte is accepted
// throughput: one byte per cycle; the parse state is updated by a single
// pass of logic from the input byte into the state and result registers
// the result register holds one item; a new byte is taken in the same cycle
// the held result leaves, so a stall on the master side stops the slave side
// only while the result register is full and not being taken
// reset clears the parse state to waiting for a fixed header and empties the
// result register
// header bytes of type 0 are discarded with an error; a length field longer
// than four bytes ends the packet with an error and the next byte is taken
// as a header again; a publish body ending before its payload, in the topic
// fields, packet id or properties, is flagged as truncated on its last byte
module mqtt_publish_packet_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] echo_byte, [11:8] packet_type, [13:12] qos_level, [14] retain_flag,
  // [30:15] topic_length, [46:31] packet_id, [74:47] remaining_length,
  // [76:75] error_code, [79:77] zero
  output logic [mqttpp_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic [3:0]  m_axis_tuser_o,   // [3:0] byte_role
  output logic        m_axis_tlast_o    // last_of_packet
);

  // parse phases
  localparam logic [3:0] PhHeader  = 4'd0;
  localparam logic [3:0] PhLength  = 4'd1;
  localparam logic [3:0] PhTlenHi  = 4'd2;
  localparam logic [3:0] PhTlenLo  = 4'd3;
  localparam logic [3:0] PhTopic   = 4'd4;
  localparam logic [3:0] PhPidHi   = 4'd5;
  localparam logic [3:0] PhPidLo   = 4'd6;
  localparam logic [3:0] PhPropLen = 4'd7;
  localparam logic [3:0] PhProp    = 4'd8;
  localparam logic [3:0] PhPayload = 4'd9;
  localparam logic [3:0] PhOther   = 4'd10;

  // parse state
  logic [3:0]         phase_q, phase_d;
  logic [7:0]         header_q, header_d;
  mqttpp_pkg::len_t   acc_q, acc_d;
  mqttpp_pkg::count_t cnt_q, cnt_d;
  mqttpp_pkg::len_t   body_q, body_d;
  logic [15:0]        topic_q, topic_d;
  mqttpp_pkg::len_t   field_q, field_d;
  logic [15:0]        pid_q, pid_d;

  // result register
  logic                                  out_valid_q;
  logic [mqttpp_pkg::OutDataW-1:0]       out_data_q, out_data_d;
  logic [mqttpp_pkg::RoleW-1:0]          out_role_q;
  logic                                  out_last_q;

  logic                         in_fire;
  logic [7:0]                   b;
  logic [3:0]                   p;
  logic [7:0]                   hdr;
  logic [mqttpp_pkg::RoleW-1:0] role;
  logic [mqttpp_pkg::ErrW-1:0]  err;
  logic                         last;
  mqttpp_pkg::len_t             body_dec;
  mqttpp_pkg::len_t             field_dec;
  logic                         is_publish;
  logic                         qos_nonzero;
  logic [15:0]                  topic_out;
  logic [15:0]                  pid_out;
  mqttpp_pkg::len_t             rlen_out;

  // result register frees up when it is empty or being taken
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign b               = s_axis_tdata_i;

  always_comb begin
    phase_d  = phase_q;
    header_d = header_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    body_d   = body_q;
    topic_d  = topic_q;
    field_d  = field_q;
    pid_d    = pid_q;
    role     = mqttpp_pkg::RoleOther;
    err      = mqttpp_pkg::ErrNone;
    last     = 1'b0;

    // unused phase codes fall back to header hunting
    p           = (phase_q > PhOther) ? PhHeader : phase_q;
    hdr         = (p == PhHeader) ? b : header_q;
    is_publish  = (header_q[7:4] == mqttpp_pkg::TypePublish);
    qos_nonzero = (header_q[2:1] != 2'd0);
    body_dec    = (body_q != '0) ? body_q - mqttpp_pkg::len_t'(1) : body_q;
    field_dec   = (field_q != '0) ? field_q - mqttpp_pkg::len_t'(1) : field_q;

    case (p)
      PhHeader: begin
        if (b[7:4] == 4'd0) begin
          role    = mqttpp_pkg::RoleDiscard;
          err     = mqttpp_pkg::ErrBadType;
          phase_d = PhHeader;
        end else begin
          role     = mqttpp_pkg::RoleHeader;
          header_d = b;
          acc_d    = '0;
          cnt_d    = '0;
          body_d   = '0;
          topic_d  = '0;
          field_d  = '0;
          pid_d    = '0;
          phase_d  = PhLength;
        end
      end
      PhLength: begin
        role  = mqttpp_pkg::RoleLength;
        acc_d = mqttpp_pkg::add_septet(acc_q, b, cnt_q);
        cnt_d = cnt_q + mqttpp_pkg::count_t'(1);
        if (b[7]) begin
          if (cnt_d >= mqttpp_pkg::count_t'(mqttpp_pkg::MaxLengthBytes)) begin
            err     = mqttpp_pkg::ErrLenLong;
            last    = 1'b1;
            phase_d = PhHeader;
          end
        end else if (acc_d == '0) begin
          // empty packet ends on its length byte
          last = 1'b1;
          if (is_publish) begin
            err = mqttpp_pkg::ErrTruncated;
          end
          phase_d = PhHeader;
        end else begin
          body_d  = acc_d;
          phase_d = is_publish ? PhTlenHi : PhOther;
        end
      end
      default: begin
        // body bytes
        body_d = body_dec;
        case (p)
          PhTlenHi: begin
            role    = mqttpp_pkg::RoleTopicLen;
            topic_d = {b, 8'h00};
            phase_d = PhTlenLo;
          end
          PhTlenLo: begin
            role    = mqttpp_pkg::RoleTopicLen;
            topic_d = topic_q | {8'h00, b};
            field_d = mqttpp_pkg::len_t'(topic_d);
            if (topic_d != 16'd0) begin
              phase_d = PhTopic;
            end else if (qos_nonzero) begin
              phase_d = PhPidHi;
            end else begin
              phase_d = PhPropLen;
              cnt_d   = '0;
              field_d = '0;
            end
          end
          PhTopic: begin
            role    = mqttpp_pkg::RoleTopic;
            field_d = field_dec;
            if (field_dec == '0) begin
              if (qos_nonzero) begin
                phase_d = PhPidHi;
              end else begin
                phase_d = PhPropLen;
                cnt_d   = '0;
              end
            end
          end
          PhPidHi: begin
            role    = mqttpp_pkg::RolePacketId;
            pid_d   = {b, 8'h00};
            phase_d = PhPidLo;
          end
          PhPidLo: begin
            role    = mqttpp_pkg::RolePacketId;
            pid_d   = pid_q | {8'h00, b};
            phase_d = PhPropLen;
            cnt_d   = '0;
            field_d = '0;
          end
          PhPropLen: begin
            role    = mqttpp_pkg::RoleProperty;
            field_d = mqttpp_pkg::add_septet(field_q, b, cnt_q);
            cnt_d   = cnt_q + mqttpp_pkg::count_t'(1);
            if (b[7]) begin
              if (cnt_d >= mqttpp_pkg::count_t'(mqttpp_pkg::MaxLengthBytes)) begin
                // rest of the body is drained as other body
                err     = mqttpp_pkg::ErrLenLong;
                phase_d = PhOther;
              end
            end else begin
              phase_d = (field_d != '0) ? PhProp : PhPayload;
            end
          end
          PhProp: begin
            role    = mqttpp_pkg::RoleProperty;
            field_d = field_dec;
            if (field_dec == '0) begin
              phase_d = PhPayload;
            end
          end
          PhPayload: begin
            role = mqttpp_pkg::RolePayload;
          end
          default: begin
            role = mqttpp_pkg::RoleOther;
          end
        endcase
        // end of body
        if (body_dec == '0) begin
          last = 1'b1;
          if (err == mqttpp_pkg::ErrNone && phase_d != PhPayload && phase_d != PhOther) begin
            err = mqttpp_pkg::ErrTruncated;
          end
          phase_d = PhHeader;
        end
      end
    endcase

    topic_out  = (p >= PhTlenLo) ? topic_d : 16'd0;
    pid_out    = (p >= PhPidLo) ? pid_d : 16'd0;
    rlen_out   = (p == PhHeader) ? '0 : acc_d;
    out_data_d = mqttpp_pkg::OutDataW'({err, rlen_out, pid_out, topic_out,
                                        hdr[0], hdr[2:1], hdr[7:4], b});
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHeader;
      header_q <= '0;
      acc_q    <= '0;
      cnt_q    <= '0;
      body_q   <= '0;
      topic_q  <= '0;
      field_q  <= '0;
      pid_q    <= '0;
    end else if (in_fire) begin
      phase_q  <= phase_d;
      header_q <= header_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      body_q   <= body_d;
      topic_q  <= topic_d;
      field_q  <= field_d;
      pid_q    <= pid_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
      out_role_q <= role;
      out_last_q <= last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_role_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// File: tb/sv/mqtt_publish_packet_parser_core_tb.sv
// self-checking testbench for the mqtt publish packet parser core
`timescale 1ns / 1ps

module mqtt_publish_packet_parser_core_tb;
  import mqttpp_pkg::*;

  localparam int unsigned ItemTarget   = 1550;
  localparam int unsigned OpeningCount = 44;
  // no idling once fewer bytes than this are waiting to be sent
  localparam int unsigned QuietTail    = 150;
  localparam int unsigned MidDrainAt   = 800;

  // parser position within a packet
  typedef enum logic [3:0] {
    PhHeader, PhLength, PhTlenHi, PhTlenLo, PhTopic, PhPidHi, PhPidLo,
    PhPropLen, PhProp, PhPayload, PhOther
  } phase_e;

  // one tagged byte, laid out as {tuser, tlast, tdata}
  typedef struct packed {
    logic [RoleW-1:0] role;
    logic             last;
    logic [2:0]       pad;
    logic [ErrW-1:0]  err;
    len_t             rlen;
    logic [15:0]      pid;
    logic [15:0]      tlen;
    logic             retain;
    logic [1:0]       qos;
    logic [3:0]       ptype;
    logic [7:0]       echo;
  } byte_tag_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                byte_valid = 1'b0;
  logic [7:0]          byte_data  = 8'h00;
  wire                 byte_ready;
  wire                 tag_valid;
  logic                tag_ready  = 1'b0;
  wire [OutDataW-1:0]  tag_data;
  wire [RoleW-1:0]     tag_role;
  wire                 tag_last;

  always #5 clk_i = ~clk_i;

  mqtt_publish_packet_parser_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (byte_valid),
    .s_axis_tready_o (byte_ready),
    .s_axis_tdata_i  (byte_data),
    .m_axis_tvalid_o (tag_valid),
    .m_axis_tready_i (tag_ready),
    .m_axis_tdata_o  (tag_data),
    .m_axis_tuser_o  (tag_role),
    .m_axis_tlast_o  (tag_last)
  );

  // bytes still to send and tags still to arrive
  logic [7:0] byte_q [$];
  byte_tag_t  tag_q  [$];
  logic [7:0] vint_q [$];
  logic [7:0] opening_bytes [OpeningCount];

  int unsigned fault_cnt = 0;
  int unsigned sent_cnt  = 0;
  int unsigned seen_cnt  = 0;

  // predicted parser state
  phase_e     ph_q         = PhHeader;
  logic [7:0] hdr_q        = 8'h00;
  len_t       len_acc_q    = '0;
  count_t     len_cnt_q    = '0;
  len_t       body_left_q  = '0;
  logic [15:0] tlen_q      = 16'h0000;
  len_t       field_left_q = '0;
  logic [15:0] pid_q       = 16'h0000;

  // add one 7-bit group of a variable-byte integer at its position
  function automatic len_t septet_sum(input len_t acc, input logic [7:0] b,
                                      input count_t idx);
    case (idx)
      3'd0:    septet_sum = acc + len_t'(b[6:0]);
      3'd1:    septet_sum = acc + len_t'({b[6:0], 7'd0});
      3'd2:    septet_sum = acc + len_t'({b[6:0], 14'd0});
      3'd3:    septet_sum = acc + len_t'({b[6:0], 21'd0});
      default: septet_sum = acc;
    endcase
  endfunction

  // after the topic: packet id only when qos is non-zero
  function automatic void after_topic();
    if (hdr_q[2:1] != 2'b00) begin
      ph_q = PhPidHi;
    end else begin
      ph_q         = PhPropLen;
      len_cnt_q    = '0;
      field_left_q = '0;
    end
  endfunction

  // advance the predicted parser by one byte and give the tag it should emit
  function automatic byte_tag_t parse_byte(input logic [7:0] b);
    byte_tag_t t;
    phase_e    p;
    logic [7:0] hdr;
    t    = '0;
    p    = ph_q;
    hdr  = (p == PhHeader) ? b : hdr_q;
    t.role = RoleOther;
    t.err  = ErrNone;
    if (p == PhHeader) begin
      if (b[7:4] == 4'h0) begin
        t.role = RoleDiscard;
        t.err  = ErrBadType;
      end else begin
        t.role       = RoleHeader;
        hdr_q        = b;
        len_acc_q    = '0;
        len_cnt_q    = '0;
        body_left_q  = '0;
        tlen_q       = 16'h0000;
        field_left_q = '0;
        pid_q        = 16'h0000;
        ph_q         = PhLength;
      end
    end else if (p == PhLength) begin
      t.role    = RoleLength;
      len_acc_q = septet_sum(len_acc_q, b, len_cnt_q);
      len_cnt_q = len_cnt_q + 3'd1;
      if (b[7]) begin
        if (len_cnt_q >= MaxLengthBytes) begin
          t.err  = ErrLenLong;
          t.last = 1'b1;
          ph_q   = PhHeader;
        end
      end else if (len_acc_q == '0) begin
        // empty packet ends on its length byte
        t.last = 1'b1;
        if (hdr_q[7:4] == TypePublish) t.err = ErrTruncated;
        ph_q = PhHeader;
      end else begin
        body_left_q = len_acc_q;
        ph_q = (hdr_q[7:4] == TypePublish) ? PhTlenHi : PhOther;
      end
    end else begin
      if (body_left_q != '0) body_left_q = body_left_q - 1'b1;
      case (p)
        PhTlenHi: begin
          t.role = RoleTopicLen;
          tlen_q = {b, 8'h00};
          ph_q   = PhTlenLo;
        end
        PhTlenLo: begin
          t.role       = RoleTopicLen;
          tlen_q       = {tlen_q[15:8], b};
          field_left_q = len_t'(tlen_q);
          if (field_left_q != '0) ph_q = PhTopic;
          else after_topic();
        end
        PhTopic: begin
          t.role = RoleTopic;
          if (field_left_q != '0) field_left_q = field_left_q - 1'b1;
          if (field_left_q == '0) after_topic();
        end
        PhPidHi: begin
          t.role = RolePacketId;
          pid_q  = {b, 8'h00};
          ph_q   = PhPidLo;
        end
        PhPidLo: begin
          t.role       = RolePacketId;
          pid_q        = {pid_q[15:8], b};
          ph_q         = PhPropLen;
          len_cnt_q    = '0;
          field_left_q = '0;
        end
        PhPropLen: begin
          t.role       = RoleProperty;
          field_left_q = septet_sum(field_left_q, b, len_cnt_q);
          len_cnt_q    = len_cnt_q + 3'd1;
          if (b[7]) begin
            // overlong property length: rest of the body is drained
            if (len_cnt_q >= MaxLengthBytes) begin
              t.err = ErrLenLong;
              ph_q  = PhOther;
            end
          end else begin
            ph_q = (field_left_q != '0) ? PhProp : PhPayload;
          end
        end
        PhProp: begin
          t.role = RoleProperty;
          if (field_left_q != '0) field_left_q = field_left_q - 1'b1;
          if (field_left_q == '0) ph_q = PhPayload;
        end
        PhPayload: t.role = RolePayload;
        default:   t.role = RoleOther;
      endcase
      if (body_left_q == '0) begin
        t.last = 1'b1;
        if (t.err == ErrNone && ph_q != PhPayload && ph_q != PhOther) begin
          t.err = ErrTruncated;
        end
        ph_q = PhHeader;
      end
    end
    t.echo   = b;
    t.ptype  = hdr[7:4];
    t.qos    = hdr[2:1];
    t.retain = hdr[0];
    t.tlen   = (p >= PhTlenLo) ? tlen_q : 16'h0000;
    t.pid    = (p >= PhPidLo) ? pid_q : 16'h0000;
    t.rlen   = (p == PhHeader) ? '0 : len_acc_q;
    return t;
  endfunction

  function automatic string describe(input byte_tag_t t);
    return $sformatf("byte %h role %0d type %0d qos %0d ret %0d tlen %h pid %h rlen %h last %0d err %0d pad %0d",
                     t.echo, t.role, t.ptype, t.qos, t.retain, t.tlen, t.pid, t.rlen,
                     t.last, t.err, t.pad);
  endfunction

  // variable-byte integer into vint_q, optionally padded with zero groups
  task automatic encode_varint(input int unsigned value, input int unsigned pad);
    int unsigned v;
    logic [7:0]  b;
    vint_q.delete();
    v = value;
    vint_q.push_back({1'b0, v[6:0]});
    v = v >> 7;
    while (v != 0) begin
      b = vint_q.pop_back();
      vint_q.push_back(b | 8'h80);
      vint_q.push_back({1'b0, v[6:0]});
      v = v >> 7;
    end
    while (pad > 0 && vint_q.size() < MaxLengthBytes) begin
      b = vint_q.pop_back();
      vint_q.push_back(b | 8'h80);
      vint_q.push_back(8'h00);
      pad--;
    end
  endtask

  function automatic int unsigned pick_pad();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // publish packet with random content; broken ones are cut short or carry
  // an overlong property length
  task automatic add_publish(input bit broken);
    logic [7:0]  body [$];
    logic [1:0]  qos;
    int unsigned tlen;
    int unsigned plen;
    int unsigned pay;
    int unsigned keep;
    bit          long_prop;
    qos  = 2'($urandom_range(0, 3));
    tlen = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    body.push_back(tlen[15:8]);
    body.push_back(tlen[7:0]);
    repeat (tlen) body.push_back(8'($urandom));
    if (qos != 2'b00) repeat (2) body.push_back(8'($urandom));
    long_prop = broken && ($urandom_range(0, 2) == 0);
    if (long_prop) begin
      repeat (4) body.push_back({1'b1, 7'($urandom)});
      repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
    end else begin
      plen = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      encode_varint(plen, pick_pad());
      foreach (vint_q[k]) body.push_back(vint_q[k]);
      repeat (plen) body.push_back(8'($urandom));
      pay = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 8);
      repeat (pay) body.push_back(8'($urandom));
    end
    keep = body.size();
    if (broken && !long_prop) keep = $urandom_range(1, body.size() - 1);
    byte_q.push_back({TypePublish, 1'($urandom), qos, 1'($urandom)});
    encode_varint(keep, pick_pad());
    foreach (vint_q[k]) byte_q.push_back(vint_q[k]);
    foreach (body[k]) if (k < keep) byte_q.push_back(body[k]);
  endtask

  task automatic add_other();
    logic [3:0]  kind;
    int unsigned n;
    kind = 4'($urandom_range(1, 15));
    while (kind == TypePublish) kind = 4'($urandom_range(1, 15));
    n = $urandom_range(0, 10);
    byte_q.push_back({kind, 4'($urandom)});
    encode_varint(n, pick_pad());
    foreach (vint_q[k]) byte_q.push_back(vint_q[k]);
    repeat (n) byte_q.push_back(8'($urandom));
  endtask

  // header then four length bytes all with the continuation bit set
  task automatic add_long_length();
    byte_q.push_back({4'($urandom_range(1, 15)), 4'($urandom)});
    repeat (4) byte_q.push_back({1'b1, 7'($urandom)});
  endtask

  // sender side
  int unsigned send_idle_pct = 0;
  int unsigned send_gap      = 0;
  bit          hold_for_drain = 1'b0;
  bit          quiet_tail     = 1'b0;
  logic        next_valid;
  logic [7:0]  next_data;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid <= 1'b0;
      byte_data  <= 8'h00;
    end else begin
      next_valid = byte_valid;
      next_data  = byte_data;
      if (byte_valid && byte_ready) begin
        tag_q.push_back(parse_byte(byte_data));
        sent_cnt++;
        next_valid = 1'b0;
        if (sent_cnt % 200 == 0) begin
          case ($urandom_range(0, 2))
            0:       send_idle_pct = 0;
            1:       send_idle_pct = 10;
            default: send_idle_pct = 40;
          endcase
        end
        // let everything drain after the opening bytes and mid-run
        if (sent_cnt == OpeningCount || sent_cnt == MidDrainAt) hold_for_drain = 1'b1;
      end
      if (!next_valid) begin
        if (hold_for_drain) begin
          if (tag_q.size() == 0) hold_for_drain = 1'b0;
        end else if (send_gap > 0) begin
          send_gap--;
        end else if (byte_q.size() != 0) begin
          if (!quiet_tail && $urandom_range(0, 99) < send_idle_pct) begin
            send_gap = $urandom_range(0, 18);
          end else begin
            next_valid = 1'b1;
            next_data  = byte_q.pop_front();
          end
        end
      end
      byte_valid <= next_valid;
      byte_data  <= next_data;
      quiet_tail <= (byte_q.size() < QuietTail);
    end
  end

  // receiver side and checking
  int unsigned recv_idle_pct = 0;
  int unsigned recv_stall    = 0;
  logic        next_ready;
  byte_tag_t   got;
  byte_tag_t   want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_ready <= 1'b0;
    end else begin
      if (tag_valid && tag_ready) begin
        got = {tag_role, tag_last, tag_data};
        seen_cnt++;
        if (tag_q.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= 10) $display("unexpected tag: %s", describe(got));
        end else begin
          want = tag_q.pop_front();
          if (got !== want) begin
            fault_cnt++;
            if (fault_cnt <= 10) begin
              $display("tag %0d mismatch", seen_cnt);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
        if (seen_cnt % 200 == 0) begin
          case ($urandom_range(0, 2))
            0:       recv_idle_pct = 0;
            1:       recv_idle_pct = 10;
            default: recv_idle_pct = 40;
          endcase
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        next_ready = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < recv_idle_pct) begin
        recv_stall = $urandom_range(0, 18);
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      tag_ready <= next_ready;
    end
  end

  initial begin
    int unsigned pick;
    // directed opening: bad type, empty packets, property and payload,
    // zero-length topic, qos 3 cut inside the packet id, overlong length,
    // overlong property length, maximum topic length cut inside the topic
    opening_bytes = '{
      8'h00,
      8'hC0, 8'h00,
      8'h30, 8'h00,
      8'h31, 8'h06, 8'h00, 8'h01, 8'h7A, 8'h01, 8'h26, 8'hFF,
      8'h32, 8'h05, 8'h00, 8'h00, 8'h12, 8'h34, 8'h00,
      8'h3F, 8'h03, 8'h00, 8'h00, 8'hAB,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'h38, 8'h07, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h55,
      8'h34, 8'h03, 8'hFF, 8'hFF, 8'h41
    };
    foreach (opening_bytes[k]) byte_q.push_back(opening_bytes[k]);
    while (byte_q.size() < ItemTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 3)) byte_q.push_back({4'h0, 4'($urandom)});
      end else if (pick < 18) begin
        add_other();
      end else if (pick < 24) begin
        add_long_length();
      end else if (pick < 36) begin
        add_publish(1'b1);
      end else begin
        add_publish(1'b0);
      end
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (byte_q.size() != 0 || byte_valid) @(posedge clk_i);
    while (tag_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fault_cnt == 0) begin
      $display("mqtt_publish_packet_parser_core regression: pass");
    end else begin
      $display("mqtt_publish_packet_parser_core regression: fail");
    end
    $finish;
  end

  // generous guard against a hung handshake
  initial begin
    #5000000;
    $display("mqtt_publish_packet_parser_core regression: fail");
    $finish;
  end

endmodule

// File: mqtt_publish_packet_parser_core.f
hw/rtl/mqttpp_pkg.sv
hw/rtl/mqtt_publish_packet_parser_core.sv
tb/sv/mqtt_publish_packet_parser_core_tb.sv
